/* design/susi_pkg.sv */
// Shared types and constants for the sorted unique set.
package susi_pkg;

	localparam int unsigned CAPACITY_DEF = 32;
	localparam int unsigned QUEUE_DEPTH  = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LIST   = 1'b1
	} cmd_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LIST   = 1'b1
	} op_t;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_LISTED    = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} item_t;

endpackage

/* design/susi_front.sv */
// Command front end: takes words from the start/busy port and decodes them for the queue.
module susi_front (
	input  logic               start,
	input  logic               command,
	input  logic signed [31:0] value,
	input  logic               queue_full,
	output logic               busy,
	output logic               push,
	output susi_pkg::item_t    item
);
	import susi_pkg::*;

	assign busy = queue_full;
	assign push = start && !queue_full;

	always_comb begin
		unique case (cmd_t'(command))
			CMD_INSERT: begin
				item.op    = OP_INSERT;
				item.value = value;
			end
			CMD_LIST: begin
				item.op    = OP_LIST;
				item.value = '0;
			end
			default: begin
				item.op    = OP_LIST;
				item.value = '0;
			end
		endcase
	end

endmodule

/* design/susi_queue.sv */
// Short command queue between the front end and the set engine.
module susi_queue #(
	parameter int unsigned DEPTH = susi_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  susi_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            valid,
	output susi_pkg::item_t head
);
	import susi_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !valid))
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

/* design/susi_back.sv */
// Set engine: a row of compare cells holding the sorted entries, plus the insert/list sequencer.
module susi_back #(
	parameter int unsigned CAPACITY = susi_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  susi_pkg::item_t    q_item,
	output logic               q_pop,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [2:0]         status,
	output logic               last
);
	import susi_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_LIST
	} state_t;

	state_t             state_q;
	logic signed [31:0] cell_q [CAPACITY];
	logic signed [31:0] cell_up [CAPACITY];
	logic signed [31:0] cell_dn [CAPACITY];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_m1;
	logic [IW-1:0]      idx_q;
	logic [CAPACITY-1:0] lt_c, eq_c, lt_q, eq_q, take_new, at_end;
	logic signed [31:0] ins_value_q;
	logic               dup, full, list_last;

	assign count_m1  = count_q - CW'(1);
	assign dup       = |eq_q;
	assign full      = (count_q == CW'(CAPACITY));
	assign list_last = (CW'(idx_q) == count_m1);
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	// Every cell compares against the queue head at once; the results form a sorted prefix mask.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign lt_c[g]   = (CW'(g) < count_q) && (cell_q[g] < q_item.value);
		assign eq_c[g]   = (CW'(g) < count_q) && (cell_q[g] == q_item.value);
		assign at_end[g] = (CW'(g) == count_m1);
		if (g == 0) begin : g_head
			assign take_new[g] = 1'b1;
			assign cell_dn[g]  = ins_value_q;
		end else begin : g_body
			assign take_new[g] = lt_q[g-1];
			assign cell_dn[g]  = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign cell_up[g] = cell_q[g];
		end else begin : g_inner
			assign cell_up[g] = cell_q[g+1];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INS && !dup && !full) begin
			// Keep cells below the slot, drop the new word in, shift the rest up.
			for (int i = 0; i < CAPACITY; i++) begin
				if (!lt_q[i]) begin
					cell_q[i] <= take_new[i] ? ins_value_q : cell_dn[i];
				end
			end
		end else if (state_q == S_LIST) begin
			// Rotate the filled prefix so the head cell walks through every entry.
			for (int i = 0; i < CAPACITY; i++) begin
				cell_q[i] <= at_end[i] ? cell_q[0] : cell_up[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			lt_q         <= '0;
			eq_q         <= '0;
			ins_value_q  <= '0;
			done         <= 1'b0;
			result_value <= '0;
			status       <= ST_INSERTED;
			last         <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == OP_INSERT) begin
							lt_q        <= lt_c;
							eq_q        <= eq_c;
							ins_value_q <= q_item.value;
							state_q     <= S_INS;
						end else if (count_q == '0) begin
							done         <= 1'b1;
							result_value <= '0;
							status       <= ST_EMPTY;
							last         <= 1'b1;
						end else begin
							idx_q   <= '0;
							state_q <= S_LIST;
						end
					end
				end
				S_INS: begin
					done         <= 1'b1;
					result_value <= ins_value_q;
					last         <= 1'b1;
					if (dup) begin
						status <= ST_DUPLICATE;
					end else if (full) begin
						status <= ST_FULL;
					end else begin
						status  <= ST_INSERTED;
						count_q <= count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				S_LIST: begin
					done         <= 1'b1;
					result_value <= cell_q[0];
					status       <= ST_LISTED;
					last         <= list_last;
					idx_q        <= idx_q + IW'(1);
					if (list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_LIST) |-> (count_q != '0))
		else $error("listing an empty set");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("insert reported without count growth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && last && status == ST_LISTED) |-> (state_q == S_IDLE))
		else $error("list run did not end on its last word");

endmodule

/* design/sorted_unique_set_insert.sv */
// Sorted unique set of signed 32-bit values: insert with duplicate/full check, ordered list.
// Flow: a command taken on start is registered in the queue, then in the compare cells, before
// its first result strobes; an empty list answers from the idle sequencer without that compare
// step. An insert gives one result and a list one per entry; the next word pops only when idle.
// busy rises only when the two-word command queue fills. Results are single-cycle strobes on
// done; the receiver cannot stall.
// arst_n clears the entry count, queue and sequencer; stored entries are not cleared.
module sorted_unique_set_insert #(
	parameter int unsigned CAPACITY = susi_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [2:0]         status,
	output logic               last
);
	import susi_pkg::*;

	item_t push_item, head_item;
	logic  push, pop, q_full, q_valid;

	susi_front u_front (
		.start      (start),
		.command    (command),
		.value      (value),
		.queue_full (q_full),
		.busy       (busy),
		.push       (push),
		.item       (push_item)
	);

	susi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (head_item)
	);

	susi_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (head_item),
		.q_pop        (pop),
		.done         (done),
		.result_value (result_value),
		.status       (status),
		.last         (last)
	);

endmodule

/* verif/sorted_unique_set_insert_tb.sv */
// Testbench for sorted_unique_set_insert: directed table, then random inserts and lists.
module sorted_unique_set_insert_tb;
	import susi_pkg::*;

	localparam int SET_DEPTH  = CAPACITY_DEF;
	localparam int RAND_WORDS = 450;
	localparam int IDLE_PCT   = 19;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] val;
		logic               typed;
		logic [2:0]         st;
	} plan_row_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic [2:0]         st;
		logic               lst;
	} set_result_t;

	localparam int NPLAN = 20;
	localparam plan_row_t DIR_PLAN [NPLAN] = '{
		'{CMD_LIST,   32'hDEAD_BEEF, 1'b1, ST_EMPTY},
		'{CMD_INSERT, 32'h8000_0000, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h8000_0000, 1'b1, ST_DUPLICATE},
		'{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DUPLICATE},
		'{CMD_LIST,   32'h0000_0000, 1'b0, ST_LISTED},
		'{CMD_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h0000_0001, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h8000_0001, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h7FFF_FFFE, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h0000_0000, 1'b1, ST_DUPLICATE},
		'{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, ST_DUPLICATE},
		'{CMD_LIST,   32'hFFFF_FFFF, 1'b0, ST_LISTED},
		'{CMD_INSERT, 32'h5555_5555, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'hAAAA_AAAA, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'h0001_0000, 1'b1, ST_INSERTED},
		'{CMD_INSERT, 32'hFFFF_0000, 1'b1, ST_INSERTED},
		'{CMD_LIST,   32'h1234_5678, 1'b0, ST_LISTED},
		'{CMD_INSERT, 32'h5555_5555, 1'b1, ST_DUPLICATE}
	};

	localparam logic signed [31:0] EDGE_VALS [7] = '{
		32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF
	};

	logic               clk;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               command = 1'b0;
	logic signed [31:0] value   = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] result_value;
	logic [2:0]         status;
	logic               last;

	logic signed [31:0] set_vals [SET_DEPTH];
	int                 set_count = 0;
	set_result_t        pending_q [$];
	int                 fail_cnt  = 0;
	bit                 gaps_on   = 1'b1;

	sorted_unique_set_insert u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.value        (value),
		.done         (done),
		.result_value (result_value),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 200000);
		$display("simulation failed");
		$finish;
	end

	// Advance the set model by one word; push its results unless a typed one stands in.
	task automatic set_model(input cmd_t cmd, input logic signed [31:0] val, input bit keep);
		int         pos;
		int         i;
		logic [2:0] st;
		pos = 0;
		if (cmd == CMD_INSERT) begin
			while (pos < set_count && set_vals[pos] < val)
				pos++;
			if (pos < set_count && set_vals[pos] == val)
				st = ST_DUPLICATE;
			else if (set_count >= SET_DEPTH)
				st = ST_FULL;
			else begin
				for (i = set_count; i > pos; i--)
					set_vals[i] = set_vals[i - 1];
				set_vals[pos] = val;
				set_count++;
				st = ST_INSERTED;
			end
			if (keep)
				pending_q.push_back('{val, st, 1'b1});
		end else if (keep) begin
			if (set_count == 0)
				pending_q.push_back('{32'sd0, ST_EMPTY, 1'b1});
			else
				for (i = 0; i < set_count; i++)
					pending_q.push_back('{set_vals[i], ST_LISTED, i == set_count - 1});
		end
	endtask

	task automatic send_word(input cmd_t cmd, input logic signed [31:0] val,
			input logic typed, input logic [2:0] typed_st);
		// idle each cycle at random while gaps are on
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		value   <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// word taken at this edge
		if (typed)
			pending_q.push_back('{(cmd == CMD_LIST) ? 32'sd0 : val, typed_st, 1'b1});
		set_model(cmd, val, !typed);
	endtask

	always @(posedge clk) begin
		set_result_t exp_r;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result: value %0d status %0d last %0b",
					$time, result_value, status, last);
			end else begin
				exp_r = pending_q.pop_front();
				if (result_value !== exp_r.val) begin
					fail_cnt++;
					$display("%0t: result_value expected %0d got %0d",
						$time, exp_r.val, result_value);
				end
				if (status !== exp_r.st) begin
					fail_cnt++;
					$display("%0t: status expected %0d got %0d", $time, exp_r.st, status);
				end
				if (last !== exp_r.lst) begin
					fail_cnt++;
					$display("%0t: last expected %0b got %0b", $time, exp_r.lst, last);
				end
			end
		end
	end

	initial begin
		int                 n;
		int                 roll;
		int                 guard;
		cmd_t               cmd;
		logic signed [31:0] val;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (n = 0; n < NPLAN; n++)
			send_word(DIR_PLAN[n].cmd, DIR_PLAN[n].val, DIR_PLAN[n].typed, DIR_PLAN[n].st);

		for (n = 0; n < RAND_WORDS; n++) begin
			// hold start high back to back through the middle stretch
			gaps_on = (n < 180 || n >= 330);
			roll = $urandom_range(99);
			val  = $urandom;
			if (roll < 12)
				cmd = CMD_LIST;
			else begin
				cmd = CMD_INSERT;
				if (roll < 42 && set_count > 0)
					val = set_vals[$urandom_range(set_count - 1)];
				else if (roll < 52)
					val = EDGE_VALS[$urandom_range(6)];
			end
			send_word(cmd, val, 1'b0, ST_INSERTED);
		end
		start <= 1'b0;

		guard = 0;
		while (pending_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * SET_DEPTH + 8) @(posedge clk);

		if (pending_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_q.size());
		if (fail_cnt == 0 && pending_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
